// ===== sv/hlcd_pkg.sv =====
// shared types and constants for the hex line to can frame decoder
// no dependencies
package hlcd_pkg;

    localparam int MAX_DATA_BYTES_DEF = 8;
    localparam int PADDR_W = 3;

    localparam logic [7:0] CR_CHAR = 8'h0D;
    localparam logic [31:0] CHECKSUM_START_RST = 32'h0000_0000;
    localparam logic [7:0] EOL_CHAR_RST = 8'h0A;

    // register index codes, taken from paddr[2]
    localparam logic REG_CHECKSUM_START = 1'b0;
    localparam logic REG_EOL_CHAR = 1'b1;

    typedef enum logic [2:0] {
        PH_SEQ  = 3'd0,
        PH_ID0  = 3'd1,
        PH_ID1  = 3'd2,
        PH_ID2  = 3'd3,
        PH_ID3  = 3'd4,
        PH_DLC  = 3'd5,
        PH_DATA = 3'd6,
        PH_DONE = 3'd7
    } t_phase;

    typedef struct packed {
        logic [31:0] checksum_start;
        logic [7:0]  eol_char;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  seq_number;
        logic [31:0] frame_id;
        logic [3:0]  frame_dlc;
        logic [63:0] frame_data;
        logic        bad_checksum;
        logic        early_end;
        logic        seq_mismatch;
        logic        too_many_chars;
        logic        dlc_too_large;
    } t_frame;

endpackage

// ===== sv/hlcd_if.sv =====
// valid/ready channel interfaces: character input and decoded frame output
// no dependencies
interface hlcd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface hlcd_frame_if;
    logic        valid;
    logic        ready;
    logic [7:0]  seq_number;
    logic [31:0] frame_id;
    logic [3:0]  frame_dlc;
    logic [63:0] frame_data;
    logic        bad_checksum;
    logic        early_end;
    logic        seq_mismatch;
    logic        too_many_chars;
    logic        dlc_too_large;

    modport source (
        output valid, input ready,
        output seq_number, output frame_id, output frame_dlc, output frame_data,
        output bad_checksum, output early_end, output seq_mismatch,
        output too_many_chars, output dlc_too_large
    );
    modport sink (
        input valid, output ready,
        input seq_number, input frame_id, input frame_dlc, input frame_data,
        input bad_checksum, input early_end, input seq_mismatch,
        input too_many_chars, input dlc_too_large
    );
endinterface

// ===== sv/hlcd_cfg.sv =====
// apb-style configuration registers: checksum start value and end of line char
// depends on hlcd_pkg
module hlcd_cfg import hlcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [31:0] r_checksum_start;
    logic [7:0]  r_eol_char;
    logic        wr_en;
    logic        reg_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[PADDR_W-1];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checksum_start <= CHECKSUM_START_RST;
            r_eol_char <= EOL_CHAR_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CHECKSUM_START: r_checksum_start <= pwdata;
                REG_EOL_CHAR:       r_eol_char <= pwdata[7:0];
                default:            r_eol_char <= r_eol_char;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CHECKSUM_START: prdata = r_checksum_start;
            REG_EOL_CHAR:       prdata = {24'h0, r_eol_char};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.checksum_start = r_checksum_start;
    assign o_cfg.eol_char = r_eol_char;

endmodule

// ===== sv/hlcd_parse.sv =====
// input register and per-character line decoder: nibble pairing, field capture,
// checksum fold and sequence check; depends on hlcd_pkg and hlcd_char_if
module hlcd_parse import hlcd_pkg::*; #(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hlcd_char_if.sink    i_in,
    input  t_cfg         i_cfg,
    input  logic         i_out_full,
    output logic         o_push,
    output t_frame       o_frame
);

    localparam int CW = $clog2(MAX_DATA_BYTES + 1);
    localparam logic [7:0] MAX_B = 8'(MAX_DATA_BYTES);

    logic                           r_in_vld;
    logic [7:0]                     r_in_char;
    t_phase                         r_phase, n_phase;
    logic                           r_want_high, n_want_high;
    logic [3:0]                     r_high, n_high;
    logic [31:0]                    r_sum, n_sum;
    logic [31:0]                    r_fold;
    logic [7:0]                     r_seq_seen, n_seq_seen;
    logic [7:0]                     r_seq_exp, n_seq_exp;
    logic [31:0]                    r_id, n_id;
    logic [3:0]                     r_dlc, n_dlc;
    logic [MAX_DATA_BYTES-1:0][7:0] r_data, n_data;
    logic [CW-1:0]                  r_cnt, n_cnt;
    logic                           r_err_csum, n_err_csum;
    logic                           r_err_seq, n_err_seq;
    logic                           r_err_extra, n_err_extra;
    logic                           r_err_dlc, n_err_dlc;

    logic        is_term;
    logic        advance;
    logic        process;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic [7:0]  dlc_clamped;
    logic [31:0] fold_a;
    logic [31:0] fold_b;
    logic [31:0] fold_c;
    logic [31:0] fold_d;
    logic [7:0]  seq_inc;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        return v;
    endfunction

    assign is_term = (r_in_char == CR_CHAR) || (r_in_char == i_cfg.eol_char);
    assign advance = !(is_term && i_out_full);
    assign process = r_in_vld && advance;
    assign i_in.ready = !r_in_vld || advance;
    assign o_push = process && is_term;

    assign nib = hex_nibble(r_in_char);
    assign byte_val = {r_high, nib};
    assign dlc_clamped = (byte_val > MAX_B) ? MAX_B : byte_val;
    assign seq_inc = r_seq_exp + 8'd1;

    // first two folds run ahead on the settled sum, the last two at checksum time
    assign fold_a = r_sum + (r_sum >> 16);
    assign fold_b = fold_a + (fold_a >> 16);
    assign fold_c = r_fold + (r_fold >> 8);
    assign fold_d = fold_c + (fold_c >> 8);

    always_comb begin
        o_frame.seq_number = r_seq_seen;
        o_frame.frame_id = r_id;
        o_frame.frame_dlc = r_dlc;
        o_frame.frame_data = 64'(r_data);
        o_frame.bad_checksum = r_err_csum;
        o_frame.early_end = (r_phase != PH_DONE);
        o_frame.seq_mismatch = r_err_seq;
        o_frame.too_many_chars = r_err_extra;
        o_frame.dlc_too_large = r_err_dlc;
    end

    always_comb begin
        n_phase = r_phase;
        n_want_high = r_want_high;
        n_high = r_high;
        n_sum = r_sum;
        n_seq_seen = r_seq_seen;
        n_seq_exp = r_seq_exp;
        n_id = r_id;
        n_dlc = r_dlc;
        n_data = r_data;
        n_cnt = r_cnt;
        n_err_csum = r_err_csum;
        n_err_seq = r_err_seq;
        n_err_extra = r_err_extra;
        n_err_dlc = r_err_dlc;
        if (process) begin
            if (is_term) begin
                n_phase = PH_SEQ;
                n_want_high = 1'b1;
                n_high = 4'h0;
                n_sum = i_cfg.checksum_start;
                n_seq_seen = 8'h00;
                n_id = '0;
                n_dlc = 4'h0;
                n_data = '0;
                n_cnt = '0;
                n_err_csum = 1'b0;
                n_err_seq = 1'b0;
                n_err_extra = 1'b0;
                n_err_dlc = 1'b0;
            end else if (r_want_high) begin
                n_want_high = 1'b0;
                n_high = nib;
            end else begin
                n_want_high = 1'b1;
                unique case (r_phase)
                    PH_SEQ: begin
                        n_seq_seen = byte_val;
                        n_sum = r_sum + {24'h0, byte_val};
                        n_phase = PH_ID0;
                    end
                    PH_ID0: begin
                        n_id[7:0] = byte_val;
                        n_sum = r_sum + {24'h0, byte_val};
                        n_phase = PH_ID1;
                    end
                    PH_ID1: begin
                        n_id[15:8] = byte_val;
                        n_sum = r_sum + {24'h0, byte_val};
                        n_phase = PH_ID2;
                    end
                    PH_ID2: begin
                        n_id[23:16] = byte_val;
                        n_sum = r_sum + {24'h0, byte_val};
                        n_phase = PH_ID3;
                    end
                    PH_ID3: begin
                        n_id[31:24] = byte_val;
                        n_sum = r_sum + {24'h0, byte_val};
                        n_phase = PH_DLC;
                    end
                    PH_DLC: begin
                        if (byte_val > MAX_B) n_err_dlc = 1'b1;
                        n_dlc = dlc_clamped[3:0];
                        n_sum = r_sum + {24'h0, dlc_clamped};
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        if (4'(r_cnt) < r_dlc) begin
                            for (int k = 0; k < MAX_DATA_BYTES; k++) begin
                                if (r_cnt == CW'(k)) n_data[k] = byte_val;
                            end
                            n_sum = r_sum + {24'h0, byte_val};
                            n_cnt = r_cnt + CW'(1);
                        end else begin
                            n_sum = fold_d;
                            if (fold_d[7:0] != byte_val) n_err_csum = 1'b1;
                            if (r_seq_seen != seq_inc) begin
                                n_err_seq = 1'b1;
                                n_seq_exp = r_seq_seen;
                            end else begin
                                n_seq_exp = seq_inc;
                            end
                            n_phase = PH_DONE;
                        end
                    end
                    PH_DONE: begin
                        n_err_extra = 1'b1;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_phase <= PH_SEQ;
            r_want_high <= 1'b1;
            r_high <= 4'h0;
            r_sum <= CHECKSUM_START_RST;
            r_seq_seen <= 8'h00;
            r_seq_exp <= 8'h00;
            r_id <= '0;
            r_dlc <= 4'h0;
            r_data <= '0;
            r_cnt <= '0;
            r_err_csum <= 1'b0;
            r_err_seq <= 1'b0;
            r_err_extra <= 1'b0;
            r_err_dlc <= 1'b0;
        end else begin
            if (i_in.ready) r_in_vld <= i_in.valid;
            r_phase <= n_phase;
            r_want_high <= n_want_high;
            r_high <= n_high;
            r_sum <= n_sum;
            r_seq_seen <= n_seq_seen;
            r_seq_exp <= n_seq_exp;
            r_id <= n_id;
            r_dlc <= n_dlc;
            r_data <= n_data;
            r_cnt <= n_cnt;
            r_err_csum <= n_err_csum;
            r_err_seq <= n_err_seq;
            r_err_extra <= n_err_extra;
            r_err_dlc <= n_err_dlc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) r_in_char <= i_in.char_in;
        r_fold <= fold_b;
    end

endmodule

// ===== sv/hlcd_obuf.sv =====
// two-entry output register with skid entry driving the frame channel
// depends on hlcd_pkg and hlcd_frame_if
module hlcd_obuf import hlcd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_frame        i_frame,
    output logic          o_full,
    hlcd_frame_if.source  o_out
);

    logic [1:0] r_cnt, n_cnt;
    t_frame     r_main, n_main;
    t_frame     r_skid, n_skid;
    logic       pop;

    assign pop = (r_cnt != 2'd0) && o_out.ready;
    assign o_full = (r_cnt == 2'd2);

    always_comb begin
        n_cnt = r_cnt;
        n_main = r_main;
        n_skid = r_skid;
        if (i_push && !pop) begin
            if (r_cnt == 2'd0) n_main = i_frame;
            else n_skid = i_frame;
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            n_main = r_skid;
            n_cnt = r_cnt - 2'd1;
        end else if (pop && i_push) begin
            if (r_cnt == 2'd1) begin
                n_main = i_frame;
            end else begin
                n_main = r_skid;
                n_skid = i_frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= 2'd0;
        else r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.seq_number = r_main.seq_number;
    assign o_out.frame_id = r_main.frame_id;
    assign o_out.frame_dlc = r_main.frame_dlc;
    assign o_out.frame_data = r_main.frame_data;
    assign o_out.bad_checksum = r_main.bad_checksum;
    assign o_out.early_end = r_main.early_end;
    assign o_out.seq_mismatch = r_main.seq_mismatch;
    assign o_out.too_many_chars = r_main.too_many_chars;
    assign o_out.dlc_too_large = r_main.dlc_too_large;

endmodule

// ===== sv/hex_line_to_can_frame_decoder.sv =====
// hex line to can frame decoder, top level: config registers, decoder, output buffer
// depends on hlcd_pkg, hlcd_if, hlcd_cfg, hlcd_parse, hlcd_obuf
// throughput: one character per cycle while the input is not stalled
// a terminator is held in the input register, then its frame enters an output buffer entry and is valid
// input stalls only while both output entries are held and a terminator waits
// reset (synchronous, active low) clears line state, sequence counter and registers
module hex_line_to_can_frame_decoder import hlcd_pkg::*; #(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hlcd_char_if.sink          i_in,
    hlcd_frame_if.source       o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg   cfg;
    t_frame frame;
    logic   push;
    logic   out_full;

    hlcd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hlcd_parse #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (cfg),
        .i_out_full (out_full),
        .o_push     (push),
        .o_frame    (frame)
    );

    hlcd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (frame),
        .o_full  (out_full),
        .o_out   (o_out)
    );

endmodule

// ===== tb/tb.sv =====
// testbench for hex_line_to_can_frame_decoder: drives hex lines and register writes, predicts
// every decoded frame and checks each one as it leaves the block
// depends on hlcd_pkg, hlcd_if and the decoder rtl
module tb;
    import hlcd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_DATA = MAX_DATA_BYTES_DEF;
    localparam int DATA_SLOTS = 8;
    localparam logic [PADDR_W-1:0] ADDR_SUM_START = {REG_CHECKSUM_START, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_EOL_CHAR = {REG_EOL_CHAR, 2'b00};

    typedef enum int {
        LINE_GOOD,
        LINE_BAD_SEQ,
        LINE_BAD_SUM,
        LINE_BIG_DLC,
        LINE_EXTRA,
        LINE_CUT,
        LINE_NOISE
    } t_line_kind;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    hlcd_char_if char_ch ();
    hlcd_frame_if frame_ch ();

    hex_line_to_can_frame_decoder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (char_ch),
        .o_out   (frame_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // decoder shadow
    logic [31:0] cfg_sum_init;
    logic [7:0] cfg_eol;
    t_phase ph;
    logic want_hi;
    logic [3:0] hi_nib;
    logic [31:0] acc_sum;
    logic [7:0] seq_next;
    int data_n;
    t_frame cur;

    t_frame frames_due[$];
    int n_mismatch = 0;
    int n_sent = 0;
    bit calm = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] nibble_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
        return 4'd0;
    endfunction

    function automatic logic [31:0] fold_sum(input logic [31:0] s);
        s += s >> 16;
        s += s >> 16;
        s += s >> 8;
        s += s >> 8;
        return s;
    endfunction

    function automatic logic [7:0] sum_byte();
        logic [31:0] s;
        s = fold_sum(acc_sum);
        return s[7:0];
    endfunction

    task automatic line_restart();
        ph = PH_SEQ;
        want_hi = 1'b1;
        hi_nib = 4'd0;
        acc_sum = cfg_sum_init;
        data_n = 0;
        cur = '0;
    endtask

    task automatic shadow_reset();
        cfg_sum_init = CHECKSUM_START_RST;
        cfg_eol = EOL_CHAR_RST;
        seq_next = 8'd0;
        line_restart();
    endtask

    task automatic absorb_byte(input logic [7:0] b_in);
        logic [7:0] b;
        logic [31:0] s;
        b = b_in;
        case (ph)
            PH_SEQ: begin
                cur.seq_number = b;
                acc_sum += b;
                ph = PH_ID0;
            end
            PH_ID0, PH_ID1, PH_ID2, PH_ID3: begin
                cur.frame_id |= 32'(b) << (8 * (ph - PH_ID0));
                acc_sum += b;
                ph = t_phase'(ph + 1);
            end
            PH_DLC: begin
                if (b > MAX_DATA) begin
                    b = 8'(MAX_DATA);
                    cur.dlc_too_large = 1'b1;
                end
                cur.frame_dlc = b[3:0];
                acc_sum += b;
                ph = PH_DATA;
            end
            PH_DATA: begin
                if (data_n < cur.frame_dlc && data_n < DATA_SLOTS) begin
                    cur.frame_data |= 64'(b) << (8 * data_n);
                    acc_sum += b;
                    data_n++;
                end else begin
                    s = fold_sum(acc_sum);
                    acc_sum = s;
                    if (s[7:0] != b) cur.bad_checksum = 1'b1;
                    seq_next++;
                    if (cur.seq_number != seq_next) begin
                        cur.seq_mismatch = 1'b1;
                        seq_next = cur.seq_number;
                    end
                    ph = PH_DONE;
                end
            end
            default: cur.too_many_chars = 1'b1;
        endcase
    endtask

    task automatic absorb_char(input logic [7:0] c);
        logic [3:0] nib;
        if (c == CR_CHAR || c == cfg_eol) begin
            if (ph != PH_DONE) cur.early_end = 1'b1;
            frames_due.push_back(cur);
            line_restart();
        end else begin
            nib = nibble_val(c);
            if (want_hi) begin
                want_hi = 1'b0;
                hi_nib = nib;
            end else begin
                want_hi = 1'b1;
                absorb_byte({hi_nib, nib});
            end
        end
    endtask

    task automatic check_field(input string tag, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("mismatch %s: expected %h, got %h", tag, want, got);
        end
    endtask

    // one item on the character channel
    task automatic send_item(input logic [7:0] c);
        if (!calm && $urandom_range(0, 7) == 0) begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.char_in <= c;
        do @(posedge clk); while (!char_ch.ready);
        n_sent++;
        absorb_char(c);
    endtask

    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_hex(c) || c == CR_CHAR || c == cfg_eol);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v == 4'd0 && $urandom_range(0, 3) == 0) return filler_char();
        if (v < 10) return 8'(v + "0");
        return 8'(v - 10 + ($urandom_range(0, 1) ? "A" : "a"));
    endfunction

    function automatic logic [7:0] end_char();
        return $urandom_range(0, 1) ? CR_CHAR : cfg_eol;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        send_item(hex_char(b[7:4]));
        send_item(hex_char(b[3:0]));
    endtask

    task automatic drain();
        char_ch.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_read(input logic [PADDR_W-1:0] addr, input logic [31:0] want);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("prdata", 64'(want), 64'(prdata));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SUM_START) begin
            cfg_sum_init = data;
            reg_read(addr, data);
        end else begin
            cfg_eol = data[7:0];
            reg_read(addr, {24'd0, data[7:0]});
        end
    endtask

    task automatic send_frame(input t_line_kind kind);
        logic [7:0] line_q[$];
        logic [7:0] dlc;
        logic [7:0] chk;
        logic [31:0] s;
        int n_data;
        int cut;
        if (kind == LINE_NOISE) begin
            repeat ($urandom_range(1, 12)) send_item(8'($urandom_range(0, 255)));
            send_item(end_char());
            return;
        end
        line_q.push_back(kind == LINE_BAD_SEQ ? seq_next + 8'd1 + 8'($urandom_range(1, 255))
                                              : seq_next + 8'd1);
        repeat (4) line_q.push_back(8'($urandom_range(0, 255)));
        if (kind == LINE_BIG_DLC)
            dlc = $urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom_range(MAX_DATA + 1, 255));
        else
            dlc = 8'($urandom_range(0, MAX_DATA));
        line_q.push_back(dlc);
        n_data = dlc > MAX_DATA ? MAX_DATA : dlc;
        repeat (n_data) line_q.push_back(8'($urandom_range(0, 255)));
        s = acc_sum;
        foreach (line_q[k]) s += (k == 5 && line_q[k] > MAX_DATA) ? 8'(MAX_DATA) : line_q[k];
        s = fold_sum(s);
        chk = s[7:0];
        if (kind == LINE_BAD_SUM) chk ^= 8'($urandom_range(1, 255));
        line_q.push_back(chk);
        if (kind == LINE_EXTRA) repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
        cut = line_q.size();
        if (kind == LINE_CUT) cut = $urandom_range(0, line_q.size() - 1);
        for (int k = 0; k < cut; k++) send_byte(line_q[k]);
        if (kind == LINE_CUT && $urandom_range(0, 1)) send_item(hex_char(4'($urandom_range(0, 15))));
        send_item(end_char());
    endtask

    function automatic t_line_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return LINE_GOOD;
        if (r < 62) return LINE_BAD_SEQ;
        if (r < 69) return LINE_BAD_SUM;
        if (r < 76) return LINE_BIG_DLC;
        if (r < 83) return LINE_EXTRA;
        if (r < 92) return LINE_CUT;
        return LINE_NOISE;
    endfunction

    task automatic test_register_reset();
        reg_read(ADDR_SUM_START, CHECKSUM_START_RST);
        reg_read(ADDR_EOL_CHAR, {24'd0, EOL_CHAR_RST});
    endtask

    task automatic test_directed_lines();
        send_item(CR_CHAR);
        send_item("7");
        send_item(cfg_eol);
        send_item(8'hFF);
        send_item("1");
        send_item("f");
        send_item("F");
        send_item(8'h00);
        send_item("0");
        send_item("A");
        send_item("5");
        send_item("3");
        send_item("c");
        send_item(8'h80);
        send_item("0");
        send_byte(sum_byte());
        send_byte(8'h7E);
        send_item(cfg_eol);
        drain();
    endtask

    // register writes while a line is half received
    task automatic test_midline_config();
        send_byte(seq_next + 8'd1);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        drain();
        cfg_write(ADDR_SUM_START, 32'hFFFF_FFFF);
        cfg_write(ADDR_EOL_CHAR, 32'h0000_0000);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'd1);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(sum_byte());
        send_item(8'h00);
        send_frame(LINE_GOOD);
        drain();
        cfg_write(ADDR_EOL_CHAR, 32'h0000_00FF);
        send_frame(LINE_GOOD);
        drain();
    endtask

    task automatic test_random_lines(input int n_items);
        int start;
        int n_lines;
        logic [31:0] sum_init;
        logic [7:0] eol;
        start = n_sent;
        n_lines = 0;
        while (n_sent - start < n_items) begin
            if (n_lines % 8 == 0) begin
                drain();
                case ($urandom_range(0, 2))
                    0: sum_init = 32'd0;
                    1: sum_init = 32'hFFFF_FFFF;
                    default: sum_init = $urandom;
                endcase
                case ($urandom_range(0, 5))
                    0: eol = EOL_CHAR_RST;
                    1: eol = 8'h00;
                    2: eol = 8'hFF;
                    3: eol = CR_CHAR;
                    4: eol = filler_char();
                    default: eol = 8'($urandom_range(0, 255));
                endcase
                cfg_write(ADDR_SUM_START, sum_init);
                cfg_write(ADDR_EOL_CHAR, {24'd0, eol});
            end
            send_frame(pick_kind());
            n_lines++;
        end
    endtask

    initial begin
        frame_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                frame_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            frame_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_frame want;
        if (rst_n && frame_ch.valid && frame_ch.ready) begin
            if (frames_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("mismatch: frame with no item pending");
            end else begin
                want = frames_due.pop_front();
                check_field("seq_number", 64'(want.seq_number), 64'(frame_ch.seq_number));
                check_field("frame_id", 64'(want.frame_id), 64'(frame_ch.frame_id));
                check_field("frame_dlc", 64'(want.frame_dlc), 64'(frame_ch.frame_dlc));
                check_field("frame_data", want.frame_data, frame_ch.frame_data);
                check_field("bad_checksum", 64'(want.bad_checksum), 64'(frame_ch.bad_checksum));
                check_field("early_end", 64'(want.early_end), 64'(frame_ch.early_end));
                check_field("seq_mismatch", 64'(want.seq_mismatch), 64'(frame_ch.seq_mismatch));
                check_field("too_many_chars", 64'(want.too_many_chars),
                            64'(frame_ch.too_many_chars));
                check_field("dlc_too_large", 64'(want.dlc_too_large),
                            64'(frame_ch.dlc_too_large));
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((char_ch.valid && char_ch.ready) || (frame_ch.valid && frame_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        rst_n <= 1'b0;
        char_ch.valid <= 1'b0;
        char_ch.char_in <= 8'd0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= 32'd0;
        shadow_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_register_reset();
        test_directed_lines();
        test_midline_config();
        test_random_lines(850);
        calm = 1;
        test_random_lines(150);
        drain();
        if (n_mismatch == 0 && frames_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
